@@ sv/cbd_pkg.sv @@
// Package for the chunked body decoder: item and result types, phase codes,
// character constants and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package cbd_pkg;

  localparam int unsigned LengthBitsDef = 24;
  localparam int unsigned LenW          = 24;
  localparam int unsigned CfgIdxW       = 1;

  localparam logic [LenW-1:0] MaxChunkRst = 24'h10_0000;
  localparam logic [LenW-1:0] OutCapRst   = 24'hFF_FFFF;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChHighA = 8'h41;
  localparam logic [7:0] ChHighF = 8'h46;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_CHUNK = 1'b0,
    CFG_OUT_CAP   = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_SIZE_FIRST  = 4'd0,
    PH_SIZE_MORE   = 4'd1,
    PH_EXT         = 4'd2,
    PH_SIZE_LF     = 4'd3,
    PH_DATA        = 4'd4,
    PH_DATA_CR     = 4'd5,
    PH_DATA_LF     = 4'd6,
    PH_TR_START    = 4'd7,
    PH_TR_CR0      = 4'd8,
    PH_TR_LINE     = 4'd9,
    PH_TR_AFTER_CR = 4'd10,
    PH_DONE        = 4'd11
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } cbd_item_t;

  typedef struct packed {
    logic            data_valid;
    logic [7:0]      data_byte;
    logic            finished;
    logic            status;
    logic [LenW-1:0] decoded_length;
  } cbd_result_t;

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= ChZero && b <= ChNine) begin
      r = {1'b1, 4'(b - ChZero)};
    end else if (b >= ChLowA && b <= ChLowF) begin
      r = {1'b1, 4'(b - ChLowA + 8'd10)};
    end else if (b >= ChHighA && b <= ChHighF) begin
      r = {1'b1, 4'(b - ChHighA + 8'd10)};
    end
    return r;
  endfunction

endpackage

@@ sv/cbd_in_stage.sv @@
// Input register of the chunked body decoder: holds one accepted byte item.
// Depends on cbd_pkg for the item type.
`timescale 1ns / 1ps

module cbd_in_stage import cbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cbd_item_t item_i,
  input  logic      advance_i,
  output logic      valid_o,
  output cbd_item_t item_o
);

  logic      valid_q;
  cbd_item_t item_q;
  logic      load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

@@ sv/cbd_parser.sv @@
// Parser state and one-byte step logic of the chunked body decoder.
// Depends on cbd_pkg for phase codes, character constants and result type.
`timescale 1ns / 1ps

module cbd_parser import cbd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  cbd_item_t       item_i,
  input  logic [LenW-1:0] max_chunk_i,
  input  logic [LenW-1:0] out_cap_i,
  output logic            res_valid_o,
  output cbd_result_t     res_o
);

  localparam int unsigned SumW = ((LENGTH_BITS > LenW) ? LENGTH_BITS : LenW) + 1;
  localparam int unsigned AccW = LenW + 4;

  phase_e                 phase_q, phase_d;
  logic [LenW-1:0]        size_q, size_d;
  logic [LenW-1:0]        left_q, left_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;

  logic [7:0]              b;
  logic                    last;
  logic [4:0]              hex;
  logic [AccW-1:0]         acc;
  logic [SumW-1:0]         need;
  logic [LENGTH_BITS+LenW-1:0] count_ext;
  logic                    fin, bad, emit, clear;

  assign b         = item_i.in_byte;
  assign last      = item_i.last_byte;
  assign hex       = hex_decode(b);
  assign acc       = (phase_q == PH_SIZE_FIRST) ? AccW'(hex[3:0]) : {size_q, hex[3:0]};
  assign need      = SumW'(count_q) + SumW'(size_q);
  assign count_ext = {{LenW{1'b0}}, count_q};

  always_comb begin
    phase_d = phase_q;
    size_d  = size_q;
    left_d  = left_q;
    count_d = count_q;
    fin     = 1'b0;
    bad     = 1'b0;
    emit    = 1'b0;
    clear   = 1'b0;

    unique case (phase_q) inside
      PH_SIZE_FIRST, PH_SIZE_MORE: begin
        if (hex[4]) begin
          if (acc > AccW'(max_chunk_i) || last) begin
            fin = 1'b1;
            bad = 1'b1;
          end else begin
            size_d  = acc[LenW-1:0];
            phase_d = PH_SIZE_MORE;
          end
        end else if (phase_q == PH_SIZE_FIRST || last) begin
          fin = 1'b1;
          bad = 1'b1;
        end else begin
          phase_d = (b == ChCr) ? PH_SIZE_LF : PH_EXT;
        end
      end
      PH_EXT: begin
        if (last) begin
          fin = 1'b1;
          bad = 1'b1;
        end else if (b == ChCr) begin
          phase_d = PH_SIZE_LF;
        end
      end
      PH_SIZE_LF: begin
        if (b != ChLf) begin
          fin = 1'b1;
          bad = 1'b1;
        end else if (size_q == '0) begin
          if (last) begin
            fin = 1'b1;
          end else begin
            phase_d = PH_TR_START;
          end
        end else if (last || need > SumW'(out_cap_i)) begin
          fin = 1'b1;
          bad = 1'b1;
        end else begin
          left_d  = size_q;
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        if (last) begin
          fin = 1'b1;
          bad = 1'b1;
        end else begin
          emit    = 1'b1;
          count_d = count_q + LENGTH_BITS'(1);
          if (left_q != '0) begin
            left_d = left_q - LenW'(1);
          end
          if (left_d == '0) begin
            phase_d = PH_DATA_CR;
          end
        end
      end
      PH_DATA_CR: begin
        if (b != ChCr || last) begin
          fin = 1'b1;
          bad = 1'b1;
        end else begin
          phase_d = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (b != ChLf || last) begin
          fin = 1'b1;
          bad = 1'b1;
        end else begin
          size_d  = '0;
          phase_d = PH_SIZE_FIRST;
        end
      end
      PH_TR_START: begin
        if (last) begin
          fin = 1'b1;
        end else begin
          phase_d = (b == ChCr) ? PH_TR_CR0 : PH_TR_LINE;
        end
      end
      PH_TR_CR0: begin
        if (last || b == ChLf) begin
          fin = 1'b1;
        end else begin
          phase_d = PH_TR_START;
        end
      end
      PH_TR_LINE: begin
        if (last) begin
          fin = 1'b1;
          bad = 1'b1;
        end else if (b == ChCr) begin
          phase_d = PH_TR_AFTER_CR;
        end
      end
      PH_TR_AFTER_CR: begin
        if (last) begin
          fin = 1'b1;
        end else begin
          phase_d = PH_TR_START;
        end
      end
      default: begin
        // Finished body: wait for the flagged last byte of the source.
        clear = last;
      end
    endcase

    if (fin) begin
      if (last) begin
        clear = 1'b1;
      end else begin
        phase_d = PH_DONE;
      end
    end
    if (clear) begin
      phase_d = PH_SIZE_FIRST;
      size_d  = '0;
      left_d  = '0;
      count_d = '0;
    end
  end

  assign res_valid_o          = emit || fin;
  assign res_o.data_valid     = emit;
  assign res_o.data_byte      = emit ? b : 8'd0;
  assign res_o.finished       = fin;
  assign res_o.status         = fin && bad;
  assign res_o.decoded_length = fin ? count_ext[LenW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE_FIRST;
      size_q  <= '0;
      left_q  <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      size_q  <= size_d;
      left_q  <= left_d;
      count_q <= count_d;
    end
  end

  a_emit_xor_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.data_valid && res_o.finished))
    else $error("payload byte and finish in the same result");

  a_data_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (left_q != '0))
    else $error("data phase with no bytes left");

  a_last_finish_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && fin && last) |=> (phase_q == PH_SIZE_FIRST && count_q == '0))
    else $error("finish on last byte did not re-arm the parser");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_DONE && !last) |=> (phase_q == PH_DONE))
    else $error("finished body left the done phase without a last byte");

endmodule

@@ sv/cbd_out_stage.sv @@
// Result register of the chunked body decoder, parted from the parser so the
// next byte is taken while a result waits. Depends on cbd_pkg.
`timescale 1ns / 1ps

module cbd_out_stage import cbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic        res_valid_i,
  input  cbd_result_t res_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output cbd_result_t res_o
);

  logic        valid_q;
  cbd_result_t res_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ sv/chunked_body_decoder.sv @@
// Chunked transfer-coding body decoder, one raw byte per item.
// Bytes wait in the input register; a parser step registers any result it gives.
// Throughput: one byte per cycle; the parser steps once per byte while the
// result register is free or being emptied.
// Reset: parser waits for a first size digit, counters clear, max chunk size
// is 0x100000 and output capacity 0xFFFFFF. Configuration writes are always accepted.
`timescale 1ns / 1ps

module chunked_body_decoder import cbd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               data_valid_o,
  output logic [7:0]         data_byte_o,
  output logic               finished_o,
  output logic               status_o,
  output logic [LenW-1:0]    decoded_length_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LenW-1:0]    cfg_data_i
);

  logic [LenW-1:0] max_chunk_q, out_cap_q;
  cbd_item_t       in_item, s1_item;
  logic            s1_valid, out_free, step, res_valid;
  cbd_result_t     res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_q <= MaxChunkRst;
      out_cap_q   <= OutCapRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_CHUNK: max_chunk_q <= cfg_data_i;
        CFG_OUT_CAP:   out_cap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.in_byte   = in_byte_i;
  assign in_item.last_byte = last_byte_i;
  assign step              = s1_valid && out_free;

  cbd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (step),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  cbd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (s1_item),
    .max_chunk_i (max_chunk_q),
    .out_cap_i   (out_cap_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cbd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign data_valid_o     = out_res.data_valid;
  assign data_byte_o      = out_res.data_byte;
  assign finished_o       = out_res.finished;
  assign status_o         = out_res.status;
  assign decoded_length_o = out_res.decoded_length;

endmodule
